>>> hdl/fcfs_pkg.sv
`timescale 1ns / 1ps

package fcfs_pkg;

  // Job store depth and derived widths
  localparam int MaxProcs = 8;
  localparam int IdxW     = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int CntW     = $clog2(MaxProcs + 1);

  // Field widths
  localparam int IdW   = 3;
  localparam int ArrW  = 16;
  localparam int BurW  = 16;
  localparam int TimeW = 20;
  localparam int SumW  = 23;

  // Segment kind codes
  localparam logic SegJob  = 1'b0;
  localparam logic SegIdle = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]  job_id;
    logic [ArrW-1:0] arrival_time;
    logic [BurW-1:0] burst_time;
    logic            last_job;
  } in_item_t;

  typedef struct packed {
    logic             segment_kind;
    logic [IdW-1:0]   seg_job_id;
    logic [TimeW-1:0] seg_start;
    logic [TimeW-1:0] seg_end;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] waiting;
    logic [SumW-1:0]  sum_turnaround;
    logic [SumW-1:0]  sum_waiting;
    logic             last_segment;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // store the input job
    logic start;  // set closed, clear schedule state
    logic step;   // examine one store entry
    logic emit;   // produce one segment into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_last;    // input item closes the set
    logic scan_end;   // entry under examination is the last stored one
    logic seg_job;    // chosen job has arrived, next segment is a job
    logic last_pick;  // chosen job is the final one of the set
    logic out_free;   // output register can take a segment
  } status_t;

endpackage

>>> hdl/fcfs_ctrl.sv
`timescale 1ns / 1ps

module fcfs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fcfs_pkg::status_t status_i,
  output fcfs_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StLoad = 3'b001,
    StScan = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StLoad: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.in_last) begin
            cmd_o.start = 1'b1;
            state_d     = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.step = 1'b1;
        if (status_i.scan_end) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          // an idle gap keeps the same job chosen
          if (status_i.seg_job) begin
            state_d = status_i.last_pick ? StLoad : StScan;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/fcfs_dp.sv
`timescale 1ns / 1ps

module fcfs_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fcfs_pkg::in_item_t  in_item_i,
  input  fcfs_pkg::cmd_t      cmd_i,
  output fcfs_pkg::status_t   status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fcfs_pkg::out_item_t out_item_o
);

  localparam int IdxW  = fcfs_pkg::IdxW;
  localparam int CntW  = fcfs_pkg::CntW;
  localparam int TimeW = fcfs_pkg::TimeW;
  localparam int SumW  = fcfs_pkg::SumW;

  // Job stores
  logic [fcfs_pkg::ArrW-1:0] arr_mem [fcfs_pkg::MaxProcs];
  logic [fcfs_pkg::BurW-1:0] bur_mem [fcfs_pkg::MaxProcs];
  logic [fcfs_pkg::IdW-1:0]  id_mem  [fcfs_pkg::MaxProcs];

  // Schedule state
  logic [CntW-1:0]                count_q, picked_q;
  logic [IdxW-1:0]                idx_q;
  logic [fcfs_pkg::MaxProcs-1:0]  done_q;
  logic                           have_q;
  logic [IdxW-1:0]                best_idx_q;
  logic [fcfs_pkg::ArrW-1:0]      best_arr_q;
  logic [fcfs_pkg::BurW-1:0]      best_bur_q;
  logic [fcfs_pkg::IdW-1:0]       best_id_q;
  logic [TimeW-1:0]               clock_q;
  logic [SumW-1:0]                tat_sum_q, wt_sum_q;

  // Registered store read; rd_idx_q holds the idx_q of the entry read
  logic                           rd_vld_q;
  logic [IdxW-1:0]                rd_idx_q;
  logic [fcfs_pkg::ArrW-1:0]      rd_arr_q;
  logic [fcfs_pkg::BurW-1:0]      rd_bur_q;
  logic [fcfs_pkg::IdW-1:0]       rd_id_q;

  logic                 out_valid_q;
  fcfs_pkg::out_item_t  out_q;

  logic                 room;
  logic                 cand;
  logic [TimeW-1:0]     at_w, seg_end, tat, wt;
  logic [SumW-1:0]      tat_sum_n, wt_sum_n;

  assign room = count_q < CntW'(fcfs_pkg::MaxProcs);

  // Entry under examination beats the best so far (strict: load order wins ties)
  assign cand = rd_vld_q && !done_q[rd_idx_q] && (!have_q || (rd_arr_q < best_arr_q));

  // Segment arithmetic for the chosen job
  assign at_w      = TimeW'(best_arr_q);
  assign seg_end   = clock_q + TimeW'(best_bur_q);
  assign tat       = seg_end - at_w;
  assign wt        = clock_q - at_w;
  assign tat_sum_n = tat_sum_q + SumW'(tat);
  assign wt_sum_n  = wt_sum_q + SumW'(wt);

  // Status
  assign status_o.in_last   = in_item_i.last_job;
  assign status_o.scan_end  = rd_vld_q && (CntW'(rd_idx_q) == (count_q - CntW'(1)));
  assign status_o.seg_job   = clock_q >= at_w;
  assign status_o.last_pick = CntW'(picked_q + CntW'(1)) == count_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // Store writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      arr_mem[count_q[IdxW-1:0]] <= in_item_i.arrival_time;
      bur_mem[count_q[IdxW-1:0]] <= in_item_i.burst_time;
      id_mem[count_q[IdxW-1:0]]  <= in_item_i.job_id;
    end
  end

  // Store read for the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      rd_arr_q <= arr_mem[idx_q];
      rd_bur_q <= bur_mem[idx_q];
      rd_id_q  <= id_mem[idx_q];
    end
  end

  // Best candidate payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && cand) begin
      best_idx_q <= rd_idx_q;
      best_arr_q <= rd_arr_q;
      best_bur_q <= rd_bur_q;
      best_id_q  <= rd_id_q;
    end
  end

  // Control state of the scan and timeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      picked_q  <= '0;
      idx_q     <= '0;
      done_q    <= '0;
      have_q    <= 1'b0;
      clock_q   <= '0;
      tat_sum_q <= '0;
      wt_sum_q  <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      if (cmd_i.load && room) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.start) begin
        picked_q  <= '0;
        idx_q     <= '0;
        done_q    <= '0;
        have_q    <= 1'b0;
        clock_q   <= '0;
        tat_sum_q <= '0;
        wt_sum_q  <= '0;
        rd_vld_q  <= 1'b0;
      end
      if (cmd_i.step) begin
        idx_q    <= idx_q + IdxW'(1);
        rd_idx_q <= idx_q;
        rd_vld_q <= 1'b1;
        if (cand) begin
          have_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        if (status_o.seg_job) begin
          done_q[best_idx_q] <= 1'b1;
          picked_q           <= picked_q + CntW'(1);
          idx_q              <= '0;
          have_q             <= 1'b0;
          rd_vld_q           <= 1'b0;
          if (status_o.last_pick) begin
            count_q   <= '0;
            clock_q   <= '0;
            tat_sum_q <= '0;
            wt_sum_q  <= '0;
          end else begin
            clock_q   <= seg_end;
            tat_sum_q <= tat_sum_n;
            wt_sum_q  <= wt_sum_n;
          end
        end else begin
          clock_q <= at_w;
        end
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (status_o.seg_job) begin
        out_q.segment_kind   <= fcfs_pkg::SegJob;
        out_q.seg_job_id     <= best_id_q;
        out_q.seg_start      <= clock_q;
        out_q.seg_end        <= seg_end;
        out_q.turnaround     <= tat;
        out_q.waiting        <= wt;
        out_q.sum_turnaround <= status_o.last_pick ? tat_sum_n : '0;
        out_q.sum_waiting    <= status_o.last_pick ? wt_sum_n : '0;
        out_q.last_segment   <= status_o.last_pick;
      end else begin
        out_q.segment_kind   <= fcfs_pkg::SegIdle;
        out_q.seg_job_id     <= '0;
        out_q.seg_start      <= clock_q;
        out_q.seg_end        <= at_w;
        out_q.turnaround     <= '0;
        out_q.waiting        <= '0;
        out_q.sum_turnaround <= '0;
        out_q.sum_waiting    <= '0;
        out_q.last_segment   <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> hdl/fcfs_schedule_timeline.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload               Handshake
// in       input      fcfs_pkg::in_item_t   in_valid_i / in_stall_o
// out      output     fcfs_pkg::out_item_t  out_valid_o / out_stall_i
//
// Loading takes one job per cycle while the input is not stalled. After the
// job marked last, each job is chosen by a scan over the job store (its
// read is registered) and then emitted as a segment, with an idle segment
// first where the clock has not yet reached its arrival.
// Reset clears control state only; job stores hold no value until loaded.
// out_stall_i holds the result register and pauses the schedule; the input
// is stalled from the last job until the final segment is registered.

module fcfs_schedule_timeline (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fcfs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fcfs_pkg::out_item_t out_item_o
);

  fcfs_pkg::cmd_t    cmd;
  fcfs_pkg::status_t status;

  fcfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fcfs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // The schedule always closes on a job segment
  a_last_is_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last_segment |->
      out_item_o.segment_kind == fcfs_pkg::SegJob)
    else $error("last segment is not a job segment");

  // Totals appear only on the final segment
  a_sums_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_segment |->
      out_item_o.sum_turnaround == '0 && out_item_o.sum_waiting == '0)
    else $error("totals on a non-final segment");

  // An idle gap always moves time forward
  a_idle_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.segment_kind == fcfs_pkg::SegIdle |->
      out_item_o.seg_start < out_item_o.seg_end)
    else $error("idle segment does not advance time");

  // Input is taken only when no segment is being produced
  a_no_load_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> in_stall_o)
    else $error("input accepted while emitting");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fcfs_pkg::*;

  localparam int QuietLimit  = 2000;  // cycles without any transfer before giving up
  localparam int DrainCycles = 100;   // wait after the last expected segment has been seen
  localparam int RandomJobs  = 104;
  localparam int CalmAfter   = 84;    // random jobs sent before idling stops

  // One row of the directed table; want only matters when typed is set
  typedef struct packed {
    in_item_t  job;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_stall_i = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // Model copy of the job store
  logic [ArrW-1:0] job_arrival [MaxProcs];
  logic [BurW-1:0] job_burst   [MaxProcs];
  logic [IdW-1:0]  job_ident   [MaxProcs];
  int              loaded_jobs = 0;

  out_item_t expected_segments [$];
  stim_row_t directed_rows [$];

  bit calm = 1'b0;
  int jobs_sent = 0;
  int jobs_dropped = 0;
  int sets_closed = 0;
  int segments_checked = 0;
  int idle_checked = 0;
  int mismatches = 0;

  fcfs_schedule_timeline dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Sort the stored jobs by arrival (stable) and walk the timeline from zero
  task automatic plan_timeline();
    int               order [MaxProcs];
    out_item_t        segs [2*MaxProcs];
    int               n, i, j, x, k;
    logic [TimeW-1:0] now, arrive, tat, wt;
    logic [SumW-1:0]  sum_tat, sum_wt;
    n = loaded_jobs;
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && job_arrival[order[j-1]] > job_arrival[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    now = '0;
    sum_tat = '0;
    sum_wt = '0;
    k = 0;
    i = 0;
    while (i < n) begin
      x = order[i];
      arrive = TimeW'(job_arrival[x]);
      segs[k] = '0;
      segs[k].seg_start = now;
      if (now >= arrive) begin
        now = now + TimeW'(job_burst[x]);
        tat = now - arrive;
        wt = tat - TimeW'(job_burst[x]);
        sum_tat = sum_tat + SumW'(tat);
        sum_wt = sum_wt + SumW'(wt);
        segs[k].segment_kind = SegJob;
        segs[k].seg_job_id = job_ident[x];
        segs[k].turnaround = tat;
        segs[k].waiting = wt;
        i++;
      end else begin
        // next job not here yet: idle up to its arrival
        segs[k].segment_kind = SegIdle;
        now = arrive;
      end
      segs[k].seg_end = now;
      k++;
    end
    segs[k-1].sum_turnaround = sum_tat;
    segs[k-1].sum_waiting = sum_wt;
    segs[k-1].last_segment = 1'b1;
    for (i = 0; i < k; i++) expected_segments.push_back(segs[i]);
  endtask

  // Store a transferred job; the one marked last closes the set
  task automatic accept_job(input in_item_t job, input logic typed, input out_item_t want);
    if (loaded_jobs < MaxProcs) begin
      job_arrival[loaded_jobs] = job.arrival_time;
      job_burst[loaded_jobs] = job.burst_time;
      job_ident[loaded_jobs] = job.job_id;
      loaded_jobs++;
    end else begin
      jobs_dropped++;
    end
    jobs_sent++;
    if (job.last_job) begin
      if (typed) expected_segments.push_back(want);
      else plan_timeline();
      loaded_jobs = 0;
      sets_closed++;
    end
  endtask

  // Hold the job until it transfers, then maybe leave a gap
  task automatic transfer_job(input in_item_t job, input logic typed, input out_item_t want);
    in_valid_i <= 1'b1;
    in_item_i <= job;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    accept_job(job, typed, want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Build one directed row; single-job sets at time zero give a segment that can be typed in directly
  task automatic add_row(input int id, input int arr, input int bur, input logic last,
                         input logic typed, input int w_end, input int w_tat, input int w_wt);
    stim_row_t row;
    row = '0;
    row.job.job_id = IdW'(id);
    row.job.arrival_time = ArrW'(arr);
    row.job.burst_time = BurW'(bur);
    row.job.last_job = last;
    row.typed = typed;
    row.want.segment_kind = SegJob;
    row.want.seg_job_id = IdW'(id);
    row.want.seg_end = TimeW'(w_end);
    row.want.turnaround = TimeW'(w_tat);
    row.want.waiting = TimeW'(w_wt);
    row.want.sum_turnaround = SumW'(w_tat);
    row.want.sum_waiting = SumW'(w_wt);
    row.want.last_segment = 1'b1;
    directed_rows.push_back(row);
  endtask

  // Mostly short times so jobs overlap and idle gaps appear, sometimes extremes
  function automatic logic [15:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 60));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare every segment transfer with the oldest expectation
  always @(posedge clk_i) begin : segment_checker
    out_item_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_segments.size() == 0) begin
        $error("segment transfer with nothing expected");
        mismatches++;
      end else begin
        want = expected_segments.pop_front();
        check_field("segment_kind", 32'(want.segment_kind),
                    32'(out_item_o.segment_kind));
        check_field("seg_job_id", 32'(want.seg_job_id), 32'(out_item_o.seg_job_id));
        check_field("seg_start", 32'(want.seg_start), 32'(out_item_o.seg_start));
        check_field("seg_end", 32'(want.seg_end), 32'(out_item_o.seg_end));
        check_field("turnaround", 32'(want.turnaround), 32'(out_item_o.turnaround));
        check_field("waiting", 32'(want.waiting), 32'(out_item_o.waiting));
        check_field("sum_turnaround", 32'(want.sum_turnaround),
                    32'(out_item_o.sum_turnaround));
        check_field("sum_waiting", 32'(want.sum_waiting),
                    32'(out_item_o.sum_waiting));
        check_field("last_segment", 32'(want.last_segment),
                    32'(out_item_o.last_segment));
        segments_checked++;
        if (want.segment_kind == SegIdle) idle_checked++;
      end
    end
  end

  // Random stall bursts on the result side, quiet once calm is set
  initial begin : result_stall
    repeat (8) @(posedge clk_i);
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) != 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Give up when nothing transfers for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    in_item_t job;
    int       set_size, s, random_sent, r;
    // single job, longest burst
    add_row(7, 0, 65535, 1'b1, 1'b1, 65535, 65535, 0);
    // all-zero job at time zero
    add_row(0, 0, 0, 1'b1, 1'b1, 0, 0, 0);
    // latest possible arrival: idle first
    add_row(5, 65535, 65535, 1'b1, 1'b0, 0, 0, 0);
    // arrival ties keep load order, gap before the later pair, zero burst
    add_row(3, 10, 5, 1'b0, 1'b0, 0, 0, 0);
    add_row(1, 2, 3, 1'b0, 1'b0, 0, 0, 0);
    add_row(6, 10, 0, 1'b0, 1'b0, 0, 0, 0);
    add_row(2, 2, 4, 1'b1, 1'b0, 0, 0, 0);
    // full store out of order, then a dropped job and a dropped closing job
    add_row(4, 65535, 65535, 1'b0, 1'b0, 0, 0, 0);
    add_row(1, 0, 65535, 1'b0, 1'b0, 0, 0, 0);
    add_row(6, 30000, 1, 1'b0, 1'b0, 0, 0, 0);
    add_row(3, 65535, 0, 1'b0, 1'b0, 0, 0, 0);
    add_row(0, 0, 0, 1'b0, 1'b0, 0, 0, 0);
    add_row(5, 12345, 54321, 1'b0, 1'b0, 0, 0, 0);
    add_row(2, 30000, 2, 1'b0, 1'b0, 0, 0, 0);
    add_row(7, 1, 65535, 1'b0, 1'b0, 0, 0, 0);
    add_row(7, 100, 1, 1'b0, 1'b0, 0, 0, 0);
    add_row(2, 0, 9, 1'b1, 1'b0, 0, 0, 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < directed_rows.size(); r++) begin
      transfer_job(directed_rows[r].job, directed_rows[r].typed, directed_rows[r].want);
    end

    // Random sets, now and then one that overflows the store
    random_sent = 0;
    while (random_sent < RandomJobs) begin
      set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(MaxProcs + 1, MaxProcs + 3)
                                             : $urandom_range(1, MaxProcs);
      for (s = 0; s < set_size; s++) begin
        job.job_id = IdW'($urandom_range(0, 7));
        job.arrival_time = pick_time();
        job.burst_time = pick_time();
        job.last_job = (s == set_size - 1);
        if (random_sent >= CalmAfter) calm = 1'b1;
        transfer_job(job, 1'b0, '0);
        random_sent++;
      end
    end
    in_valid_i <= 1'b0;

    while (expected_segments.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d jobs in %0d sets transferred, %0d dropped at a full store",
             jobs_sent, sets_closed, jobs_dropped);
    $display("%0d segments checked, %0d of them idle", segments_checked, idle_checked);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
